@@ rtl/vse_pkg.sv @@
package vse_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int WORD_W      = 64;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int DEPTH_W     = 8;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_DUP   = 3'd3,
		OP_SWAP  = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_FEW   = 2'd3
	} status_t;

endpackage

@@ rtl/vse_if.sv @@
interface vse_in_if import vse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [WORD_W-1:0] data_in;

	modport source (output valid, output operation, output data_in, input ready);
	modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface vse_out_if import vse_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   data_out;
	logic [STATUS_W-1:0] status;
	logic                is_empty;
	logic [DEPTH_W-1:0]  depth;

	modport source (output valid, output data_out, output status, output is_empty,
		output depth, input ready);
	modport sink   (input valid, input data_out, input status, input is_empty,
		input depth, output ready);
endinterface

@@ rtl/value_stack_engine_core.sv @@
// LIFO stack of 64-bit words held in a single-port-write, one-read synchronous RAM.
// in_ch  : one transaction per command (operation, data_in); data_in matters for push only.
// out_ch : exactly one transaction per command, in command order: data_out (popped or
//          peeked word, zero otherwise), status, is_empty and depth after the command.
// One command is worked at a time. After input accept, push, clear and refused commands
// go straight to S_FIN; pop, peek and duplicate pass S_RD1; swap passes S_RD1, S_RD2
// and S_WR2, set by the registered RAM read and single write port (a swap needs two
// reads and two writes). S_FIN loads the output register; in_ch.ready rises again the
// cycle after the result is loaded; no new command is taken while one is in work.
// The output register parts the two sides: a new command is taken while the previous
// result still waits. If the receiver stalls, the finished result of the next command
// waits in the engine until the output register frees up, and input stalls with it.
// Reset (arst_n low) empties the stack and drops any pending result. The RAM itself
// is not cleared; only entries below the depth are ever read, and all were written
// since the last reset or clear, so no clearing pass is needed.
module value_stack_engine_core import vse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	vse_in_if.sink      in_ch,
	vse_out_if.source   out_ch
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_WR2,
		S_FIN
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [WORD_W-1:0]   tmp_q;
	logic [WORD_W-1:0]   res_data_q;
	status_t             res_status_q;

	logic                out_valid_q;
	logic [WORD_W-1:0]   out_data_q;
	status_t             out_status_q;
	logic                out_empty_q;
	logic [DEPTH_W-1:0]  out_depth_q;

	// storage
	logic [WORD_W-1:0]   mem [STACK_DEPTH];
	logic [WORD_W-1:0]   rd_data_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;

	logic                in_acc;
	op_t                 in_op;
	logic                is_zero;
	logic                is_full;
	logic                is_few;
	logic                out_free;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign in_op       = op_t'(in_ch.operation);
	assign is_zero     = (cnt_q == '0);
	assign is_full     = (cnt_q == CNT_W'(STACK_DEPTH));
	assign is_few      = (cnt_q < CNT_W'(2));
	assign out_free    = !out_valid_q || out_ch.ready;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.data_out = out_data_q;
	assign out_ch.status   = out_status_q;
	assign out_ch.is_empty = out_empty_q;
	assign out_ch.depth    = out_depth_q;

	// RAM port control: top of stack is entry cnt-1
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_op == OP_PUSH && !is_full) begin
						mem_we    = 1'b1;
						mem_waddr = ADDR_W'(cnt_q);
						mem_wdata = in_ch.data_in;
					end
					if (((in_op == OP_POP || in_op == OP_PEEK) && !is_zero) ||
						(in_op == OP_DUP && !is_zero && !is_full) ||
						(in_op == OP_SWAP && !is_few)) begin
						mem_re    = 1'b1;
						mem_raddr = ADDR_W'(cnt_q - CNT_W'(1));
					end
				end
			end
			S_RD1: begin
				if (op_q == OP_DUP) begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(cnt_q);
					mem_wdata = rd_data_q;
				end
				if (op_q == OP_SWAP) begin
					mem_re    = 1'b1;
					mem_raddr = ADDR_W'(cnt_q - CNT_W'(2));
				end
			end
			S_RD2: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(cnt_q - CNT_W'(1));
				mem_wdata = rd_data_q;
			end
			S_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(cnt_q - CNT_W'(2));
				mem_wdata = tmp_q;
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			op_q         <= OP_PUSH;
			res_status_q <= ST_OK;
			out_status_q <= ST_OK;
		end else begin
			// in S_FIN a drained output register is reloaded instead
			if (out_valid_q && out_ch.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q         <= in_op;
						res_data_q   <= '0;
						res_status_q <= ST_OK;
						state_q      <= S_FIN;
						unique case (in_op)
							OP_PUSH: begin
								if (is_full) res_status_q <= ST_OVER;
								else         cnt_q        <= cnt_q + CNT_W'(1);
							end
							OP_POP: begin
								if (is_zero) begin
									res_status_q <= ST_UNDER;
								end else begin
									cnt_q   <= cnt_q - CNT_W'(1);
									state_q <= S_RD1;
								end
							end
							OP_PEEK: begin
								if (is_zero) res_status_q <= ST_UNDER;
								else         state_q      <= S_RD1;
							end
							OP_DUP: begin
								if (is_zero)      res_status_q <= ST_UNDER;
								else if (is_full) res_status_q <= ST_OVER;
								else              state_q      <= S_RD1;
							end
							OP_SWAP: begin
								if (is_few) res_status_q <= ST_FEW;
								else        state_q      <= S_RD1;
							end
							OP_CLEAR: cnt_q <= '0;
							default: begin
							end
						endcase
					end
				end
				S_RD1: begin
					unique case (op_q)
						OP_POP, OP_PEEK: begin
							res_data_q <= rd_data_q;
							state_q    <= S_FIN;
						end
						OP_DUP: begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= S_FIN;
						end
						OP_SWAP: begin
							tmp_q   <= rd_data_q;
							state_q <= S_RD2;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_RD2: state_q <= S_WR2;
				S_WR2: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= res_data_q;
						out_status_q <= res_status_q;
						out_empty_q  <= is_zero;
						out_depth_q  <= DEPTH_W'(cnt_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// count never passes the store size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond store size");

	// writes land no higher than entry cnt, one above the current top
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CNT_W'(mem_waddr) <= cnt_q))
		else $error("stack write above top");

	// count moves only on an accepted command or a duplicate write-back
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_acc && state_q != S_RD1) |=> $stable(cnt_q))
		else $error("stack count changed unexpectedly");

	// refused commands carry a zero word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> (out_data_q == '0))
		else $error("nonzero data on error result");

endmodule

@@ bench/vse_stack_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow stack and compares every result
// transaction with the oldest expected one.
module vse_stack_checker import vse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	vse_in_if    in_mon,
	vse_out_if   out_mon,
	output int   fail_count,
	output int   outstanding
);

	typedef struct packed {
		logic [WORD_W-1:0]  word;
		status_t            status;
		logic               empty;
		logic [DEPTH_W-1:0] depth;
	} stack_result_t;

	logic [WORD_W-1:0] shadow_store [STACK_DEPTH];
	int                shadow_count;
	stack_result_t     expected_q [$];

	// Applies one command to the shadow stack and returns what the block must answer.
	function automatic stack_result_t apply_command(input logic [OP_W-1:0] op,
		input logic [WORD_W-1:0] word);
		stack_result_t     res;
		logic [WORD_W-1:0] held;
		res.word   = '0;
		res.status = ST_OK;
		case (op)
			OP_PUSH: begin
				if (shadow_count >= STACK_DEPTH) begin
					res.status = ST_OVER;
				end else begin
					shadow_store[shadow_count] = word;
					shadow_count++;
				end
			end
			OP_POP: begin
				if (shadow_count == 0) begin
					res.status = ST_UNDER;
				end else begin
					shadow_count--;
					res.word = shadow_store[shadow_count];
				end
			end
			OP_PEEK: begin
				if (shadow_count == 0)
					res.status = ST_UNDER;
				else
					res.word = shadow_store[shadow_count-1];
			end
			OP_DUP: begin
				if (shadow_count == 0) begin
					res.status = ST_UNDER;
				end else if (shadow_count >= STACK_DEPTH) begin
					res.status = ST_OVER;
				end else begin
					shadow_store[shadow_count] = shadow_store[shadow_count-1];
					shadow_count++;
				end
			end
			OP_SWAP: begin
				if (shadow_count < 2) begin
					res.status = ST_FEW;
				end else begin
					held                         = shadow_store[shadow_count-2];
					shadow_store[shadow_count-2] = shadow_store[shadow_count-1];
					shadow_store[shadow_count-1] = held;
				end
			end
			OP_CLEAR: shadow_count = 0;
			default: ;
		endcase
		res.empty = (shadow_count == 0);
		res.depth = DEPTH_W'(shadow_count);
		return res;
	endfunction

	function automatic void compare_result(input stack_result_t exp_r);
		if (out_mon.data_out !== exp_r.word) begin
			$display("%0t: data_out expected %h actual %h", $time, exp_r.word, out_mon.data_out);
			fail_count++;
		end
		if (out_mon.status !== exp_r.status) begin
			$display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_mon.status);
			fail_count++;
		end
		if (out_mon.is_empty !== exp_r.empty) begin
			$display("%0t: is_empty expected %b actual %b", $time, exp_r.empty,
				out_mon.is_empty);
			fail_count++;
		end
		if (out_mon.depth !== exp_r.depth) begin
			$display("%0t: depth expected %0d actual %0d", $time, exp_r.depth, out_mon.depth);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_result_t head;
		if (!arst_n) begin
			shadow_count = 0;
			expected_q.delete();
			outstanding = 0;
			fail_count  = 0;
		end else begin
			if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
				expected_q.push_back(apply_command(in_mon.operation, in_mon.data_in));
			if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with none expected, data_out %h status %0d",
						$time, out_mon.data_out, out_mon.status);
					fail_count++;
				end else begin
					head = expected_q.pop_front();
					compare_result(head);
				end
			end
			outstanding = expected_q.size();
		end
	end

endmodule

@@ bench/value_stack_engine_core_tb.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the stack engine. Checking lives in vse_stack_checker.
module value_stack_engine_core_tb;
	import vse_pkg::*;

	// op codes the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	// receiver hold-off used to back the engine up into its input
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AT_ITEM = 400;

	// no idling on either side while the transaction count is in this window
	localparam int QUIET_FROM = 600;
	localparam int QUIET_TO   = 800;

	// random part is shaped in segments: fill toward full, drain toward empty, mixed
	typedef enum int {SHAPE_FILL, SHAPE_DRAIN, SHAPE_MIX} shape_t;

	localparam int SEG_COUNT = 6;

	logic clk;
	logic arst_n;
	int   items_sent;
	int   fail_count;
	int   outstanding;
	logic hold_done;
	wire  quiet = (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);

	vse_in_if  in_ch ();
	vse_out_if out_ch ();

	value_stack_engine_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	vse_stack_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mon      (in_ch),
		.out_mon     (out_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("[value_stack_engine_core] ERROR");
		$finish;
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Op mix per segment shape. Fill is push/dup heavy enough to hit the
	// full limit and draw overflow; drain runs the stack dry into underflow.
	function automatic logic [OP_W-1:0] pick_op(input shape_t shape);
		int r;
		r = $urandom_range(99);
		case (shape)
			SHAPE_FILL: begin
				if (r < 70)      return OP_PUSH;
				else if (r < 85) return OP_DUP;
				else if (r < 90) return OP_PEEK;
				else if (r < 94) return OP_SWAP;
				else if (r < 97) return OP_POP;
				else             return $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
			end
			SHAPE_DRAIN: begin
				if (r < 70)      return OP_POP;
				else if (r < 80) return OP_PEEK;
				else if (r < 88) return OP_SWAP;
				else if (r < 93) return OP_PUSH;
				else if (r < 97) return OP_DUP;
				else             return OP_CLEAR;
			end
			default: begin
				if (r < 30)      return OP_PUSH;
				else if (r < 55) return OP_POP;
				else if (r < 67) return OP_PEEK;
				else if (r < 77) return OP_DUP;
				else if (r < 89) return OP_SWAP;
				else if (r < 92) return OP_CLEAR;
				else             return $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
			end
		endcase
	endfunction

	// Offers one command transaction, with random idle cycles ahead of it,
	// and returns once it has been taken.
	task automatic send_command(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
		while (!quiet && $urandom_range(99) < 33) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.operation <= op;
		in_ch.data_in   <= word;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
	endtask

	// Result side: random stalls, one long hold-off while the sender keeps
	// offering, and a stall-free window shared with the sender.
	initial begin
		hold_done = 1'b0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ch.ready <= quiet || ($urandom_range(99) >= 33);
			end
		end
	end

	initial begin
		shape_t seg_shape [SEG_COUNT];
		int     seg_len [SEG_COUNT];
		seg_shape = '{SHAPE_FILL, SHAPE_MIX, SHAPE_DRAIN, SHAPE_FILL, SHAPE_MIX, SHAPE_DRAIN};
		seg_len   = '{200, 150, 200, 220, 140, 140};
		items_sent = 0;
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.operation <= OP_PUSH;
		in_ch.data_in   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every refusal on an empty or short stack, data extremes,
		// every op on a small stack, the ignored op codes, and clear.
		send_command(OP_POP,   rand_word());   // underflow on empty
		send_command(OP_PEEK,  rand_word());   // underflow on empty
		send_command(OP_DUP,   rand_word());   // dup refused on empty
		send_command(OP_SWAP,  rand_word());   // swap with no entries
		send_command(OP_PUSH,  '0);
		send_command(OP_SWAP,  rand_word());   // swap with a single entry
		send_command(OP_PUSH,  '1);
		send_command(OP_PEEK,  '0);
		send_command(OP_SWAP,  '1);
		send_command(OP_PEEK,  rand_word());
		send_command(OP_DUP,   rand_word());
		send_command(OP_PUSH,  64'hAAAA_AAAA_AAAA_AAAA);
		send_command(OP_PUSH,  64'h5555_5555_5555_5555);
		send_command(OP_SWAP,  rand_word());
		send_command(OP_SPARE_LO, '1);
		send_command(OP_SPARE_HI, '1);
		send_command(OP_POP,   rand_word());
		send_command(OP_POP,   rand_word());
		send_command(OP_POP,   rand_word());
		send_command(OP_PUSH,  64'h8000_0000_0000_0001);
		send_command(OP_CLEAR, rand_word());   // drops all three remaining entries
		send_command(OP_PEEK,  rand_word());   // nothing left after clear
		send_command(OP_CLEAR, rand_word());   // clear on empty
		send_command(OP_PUSH,  rand_word());
		send_command(OP_POP,   rand_word());

		for (int s = 0; s < SEG_COUNT; s++)
			for (int i = 0; i < seg_len[s]; i++)
				send_command(pick_op(seg_shape[s]), rand_word());

		in_ch.valid <= 1'b0;

		// drain: let the checker log the last command, then wait for results
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("[value_stack_engine_core] OK");
		else
			$display("[value_stack_engine_core] ERROR");
		$finish;
	end

endmodule
